// ===== design/tfe_pkg.sv =====
// Shared types, codes and helper functions for the TZif footer extractor.
`timescale 1ns / 1ps

package tfe_pkg;

  localparam int PENDING_DEPTH_DEFAULT = 16;

  // Command queue between the parser and the result stage.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  // Wide enough for the weighted sum of six 31-bit counts.
  localparam int SKIP_W = 38;

  // Result kinds.
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Error codes.
  localparam logic [2:0] E_MAGIC    = 3'd0;
  localparam logic [2:0] E_VERSION  = 3'd1;
  localparam logic [2:0] E_RESERVED = 3'd2;
  localparam logic [2:0] E_NEGATIVE = 3'd3;
  localparam logic [2:0] E_V1       = 3'd4;
  localparam logic [2:0] E_TRUNC    = 3'd5;
  localparam logic [2:0] E_OVERFLOW = 3'd6;

  // Command opcodes.
  localparam logic [1:0] OP_WS   = 2'd0;
  localparam logic [1:0] OP_CHAR = 2'd1;
  localparam logic [1:0] OP_DONE = 2'd2;
  localparam logic [1:0] OP_ERR  = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] value;
    logic [2:0] code;
    logic       eof;
  } cmd_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] p);
    logic [7:0] m;
    case (p)
      2'd0: m = 8'h54;
      2'd1: m = 8'h5A;
      2'd2: m = 8'h69;
      default: m = 8'h66;
    endcase
    return m;
  endfunction

  // Bytes per entry of each count in the first and second body.
  function automatic logic [3:0] count_weight(input logic second, input logic [2:0] k);
    logic [3:0] w;
    case (k)
      3'd2: w = second ? 4'd12 : 4'd8;
      3'd3: w = second ? 4'd9 : 4'd5;
      3'd4: w = 4'd6;
      default: w = 4'd1;
    endcase
    return w;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

endpackage

// ===== design/tfe_front.sv =====
// Parser front end: header checks, body skipping and footer word classification.
`timescale 1ns / 1ps

module tfe_front #(
  parameter int PENDING_DEPTH = tfe_pkg::PENDING_DEPTH_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   byte_valid,
  output logic                                   byte_ready,
  input  logic [7:0]                             data_byte,
  input  logic                                   end_of_file,
  input  logic                                   q_full,
  output logic                                   cmd_push,
  output tfe_pkg::cmd_t                          cmd,
  output logic [$clog2(PENDING_DEPTH+1)-1:0]     cmd_count
);
  import tfe_pkg::*;

  localparam int CW = $clog2(PENDING_DEPTH + 1);

  localparam logic [2:0] PH_HDR1   = 3'd0;
  localparam logic [2:0] PH_BODY1  = 3'd1;
  localparam logic [2:0] PH_HDR2   = 3'd2;
  localparam logic [2:0] PH_BODY2  = 3'd3;
  localparam logic [2:0] PH_FOOTER = 3'd4;
  localparam logic [2:0] PH_WAIT   = 3'd5;

  logic [2:0]        phase, phase_next;
  logic [5:0]        pos, pos_next;
  logic [31:0]       csr, csr_next;
  logic [7:0]        ver, ver_next;
  logic [SKIP_W-1:0] skip, skip_next;
  logic              started, started_next;
  logic [CW-1:0]     pcount, pcount_next;

  logic              accept;
  logic              second;
  logic [5:0]        pk;
  logic [31:0]       csr_shift;
  logic [35:0]       weighted;
  logic [SKIP_W-1:0] skip_add;
  logic              err;
  logic [2:0]        err_code;

  assign byte_ready = !q_full;
  assign accept     = byte_valid && byte_ready;
  assign second     = (phase == PH_HDR2);
  assign pk         = pos - 6'd20;
  assign csr_shift  = {csr[23:0], data_byte};
  assign weighted   = {4'b0, csr_shift} * {32'b0, count_weight(second, pk[4:2])};
  assign skip_add   = skip + {{(SKIP_W-36){1'b0}}, weighted};

  always_comb begin
    phase_next   = phase;
    pos_next     = pos;
    csr_next     = csr;
    ver_next     = ver;
    skip_next    = skip;
    started_next = started;
    pcount_next  = pcount;
    cmd_push     = 1'b0;
    cmd          = '0;
    cmd_count    = '0;
    err          = 1'b0;
    err_code     = E_MAGIC;

    if (accept) begin
      case (phase)
        PH_HDR1, PH_HDR2: begin
          if (pos < 6'd4) begin
            if (data_byte != magic_byte(pos[1:0])) begin
              err      = 1'b1;
              err_code = E_MAGIC;
            end
          end else if (pos == 6'd4) begin
            if (data_byte != 8'h00 && data_byte != 8'h32 && data_byte != 8'h33) begin
              err      = 1'b1;
              err_code = E_VERSION;
            end else if (!second) begin
              ver_next = data_byte;
            end
          end else if (pos < 6'd20) begin
            if (data_byte != 8'h00) begin
              err      = 1'b1;
              err_code = E_RESERVED;
            end
          end else begin
            if (pk[1:0] == 2'd0 && data_byte[7]) begin
              err      = 1'b1;
              err_code = E_NEGATIVE;
            end else begin
              csr_next = csr_shift;
              if (pk[1:0] == 2'd3) begin
                skip_next = skip_add;
              end
            end
          end
          if (!err) begin
            if (pos >= 6'd43) begin
              pos_next = '0;
              csr_next = '0;
              if (!second && ver == 8'h00) begin
                err      = 1'b1;
                err_code = E_V1;
              end else if (second) begin
                phase_next = (skip_next != '0) ? PH_BODY2 : PH_FOOTER;
              end else begin
                phase_next = (skip_next != '0) ? PH_BODY1 : PH_HDR2;
              end
            end else begin
              pos_next = pos + 6'd1;
            end
          end
        end
        PH_BODY1, PH_BODY2: begin
          skip_next = skip - SKIP_W'(1);
          if (skip == SKIP_W'(1)) begin
            phase_next = (phase == PH_BODY1) ? PH_HDR2 : PH_FOOTER;
          end
        end
        PH_FOOTER: begin
          if (is_space(data_byte)) begin
            if (started && !end_of_file) begin
              if (pcount == CW'(PENDING_DEPTH)) begin
                err      = 1'b1;
                err_code = E_OVERFLOW;
              end else begin
                // Interior whitespace goes to the hold buffer at slot pcount.
                cmd_push    = 1'b1;
                cmd.op      = OP_WS;
                cmd.value   = data_byte;
                cmd_count   = pcount;
                pcount_next = pcount + CW'(1);
              end
            end
            if (!err && end_of_file) begin
              cmd_push = 1'b1;
              cmd.op   = OP_DONE;
            end
          end else begin
            cmd_push     = 1'b1;
            cmd.op       = OP_CHAR;
            cmd.value    = data_byte;
            cmd.eof      = end_of_file;
            cmd_count    = pcount;
            pcount_next  = '0;
            started_next = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (err) begin
        cmd_push   = 1'b1;
        cmd        = '0;
        cmd.op     = OP_ERR;
        cmd.code   = err_code;
        cmd_count  = '0;
        phase_next = PH_WAIT;
      end else if (end_of_file && phase_next != PH_FOOTER && phase_next != PH_WAIT) begin
        cmd_push = 1'b1;
        cmd.op   = OP_ERR;
        cmd.code = E_TRUNC;
      end else if (end_of_file && phase != PH_FOOTER && phase_next == PH_FOOTER) begin
        // The word that ended the second header or body also ends the file: empty footer.
        cmd_push = 1'b1;
        cmd.op   = OP_DONE;
      end

      if (end_of_file) begin
        phase_next   = PH_HDR1;
        pos_next     = '0;
        csr_next     = '0;
        ver_next     = '0;
        skip_next    = '0;
        started_next = 1'b0;
        pcount_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HDR1;
      pos     <= '0;
      csr     <= '0;
      ver     <= '0;
      skip    <= '0;
      started <= 1'b0;
      pcount  <= '0;
    end else begin
      phase   <= phase_next;
      pos     <= pos_next;
      csr     <= csr_next;
      ver     <= ver_next;
      skip    <= skip_next;
      started <= started_next;
      pcount  <= pcount_next;
    end
  end

`ifndef ASSERT_OFF
  a_pcount_bound: assert property (@(posedge clk) disable iff (rst)
    pcount <= CW'(PENDING_DEPTH))
    else $error("held whitespace count beyond buffer depth");

  a_held_needs_start: assert property (@(posedge clk) disable iff (rst)
    !started |-> (pcount == '0))
    else $error("whitespace held before the footer started");
`endif

endmodule

// ===== design/tfe_queue.sv =====
// Short command queue between the parser and the result stage.
`timescale 1ns / 1ps

module tfe_queue #(
  parameter int PENDING_DEPTH = tfe_pkg::PENDING_DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  tfe_pkg::cmd_t                      push_cmd,
  input  logic [$clog2(PENDING_DEPTH+1)-1:0] push_count,
  input  logic                               pop,
  output logic                               full,
  output logic                               empty,
  output tfe_pkg::cmd_t                      head_cmd,
  output logic [$clog2(PENDING_DEPTH+1)-1:0] head_count
);
  import tfe_pkg::*;

  localparam int CW = $clog2(PENDING_DEPTH + 1);

  cmd_t              q_cmd [QUEUE_DEPTH];
  logic [CW-1:0]     q_cnt [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full       = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty      = (fill == '0);
  assign head_cmd   = q_cmd[rd_ptr];
  assign head_count = q_cnt[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_cmd[wr_ptr] <= push_cmd;
      q_cnt[wr_ptr] <= push_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QPTR_W+1)'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("command queue written while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("command queue read while empty");
`endif

endmodule

// ===== design/tfe_back.sv =====
// Result stage: whitespace hold buffer, flush sequencing and the output register.
`timescale 1ns / 1ps

module tfe_back #(
  parameter int PENDING_DEPTH = tfe_pkg::PENDING_DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tfe_pkg::cmd_t                      head_cmd,
  input  logic [$clog2(PENDING_DEPTH+1)-1:0] head_count,
  input  logic                               empty,
  output logic                               pop,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic [1:0]                         kind,
  output logic [7:0]                         char_byte,
  output logic [2:0]                         error_code,
  output logic                               last_of_run
);
  import tfe_pkg::*;

  localparam int CW = $clog2(PENDING_DEPTH + 1);
  localparam int IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_FLUSH_A = 3'd1;
  localparam logic [2:0] ST_FLUSH_D = 3'd2;
  localparam logic [2:0] ST_CHAR    = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  logic [7:0]    mem [PENDING_DEPTH];
  logic [7:0]    rd_data;
  logic          mem_we;

  logic [2:0]    state, state_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] flush_n;
  logic [7:0]    held_char;
  logic          held_eof;

  logic          can_load;
  logic          load;
  logic [1:0]    ld_kind;
  logic [7:0]    ld_char;
  logic [2:0]    ld_code;
  logic          ld_last;

  assign can_load = !result_valid || result_ready;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    pop        = 1'b0;
    mem_we     = 1'b0;
    load       = 1'b0;
    ld_kind    = KIND_CHAR;
    ld_char    = '0;
    ld_code    = '0;
    ld_last    = 1'b0;

    case (state)
      ST_IDLE: begin
        if (!empty) begin
          case (head_cmd.op)
            OP_WS: begin
              pop    = 1'b1;
              mem_we = 1'b1;
            end
            OP_CHAR: begin
              if (can_load) begin
                pop = 1'b1;
                if (head_count == '0) begin
                  load    = 1'b1;
                  ld_kind = KIND_CHAR;
                  ld_char = head_cmd.value;
                  ld_last = !head_cmd.eof;
                  if (head_cmd.eof) begin
                    state_next = ST_DONE;
                  end
                end else begin
                  idx_next   = '0;
                  state_next = ST_FLUSH_A;
                end
              end
            end
            OP_DONE: begin
              if (can_load) begin
                pop     = 1'b1;
                load    = 1'b1;
                ld_kind = KIND_DONE;
                ld_last = 1'b1;
              end
            end
            OP_ERR: begin
              if (can_load) begin
                pop     = 1'b1;
                load    = 1'b1;
                ld_kind = KIND_ERR;
                ld_code = head_cmd.code;
                ld_last = 1'b1;
              end
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      ST_FLUSH_A: begin
        // The buffer read issued at idx lands in rd_data on this edge.
        state_next = ST_FLUSH_D;
      end
      ST_FLUSH_D: begin
        if (can_load) begin
          load    = 1'b1;
          ld_kind = KIND_CHAR;
          ld_char = rd_data;
          if (idx + CW'(1) == flush_n) begin
            state_next = ST_CHAR;
          end else begin
            idx_next   = idx + CW'(1);
            state_next = ST_FLUSH_A;
          end
        end
      end
      ST_CHAR: begin
        if (can_load) begin
          load       = 1'b1;
          ld_kind    = KIND_CHAR;
          ld_char    = held_char;
          ld_last    = !held_eof;
          state_next = held_eof ? ST_DONE : ST_IDLE;
        end
      end
      ST_DONE: begin
        if (can_load) begin
          load       = 1'b1;
          ld_kind    = KIND_DONE;
          ld_last    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[head_count[IW-1:0]] <= head_cmd.value;
    end
    rd_data <= mem[idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pop && head_cmd.op == OP_CHAR) begin
      held_char <= head_cmd.value;
      held_eof  <= head_cmd.eof;
      flush_n   <= head_count;
    end
    if (load) begin
      kind        <= ld_kind;
      char_byte   <= ld_char;
      error_code  <= ld_code;
      last_of_run <= ld_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_flush_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH_D) |-> (idx < flush_n))
    else $error("flush index ran past the held whitespace count");

  a_code_only_on_error: assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind != KIND_ERR) |-> (error_code == '0))
    else $error("error code set on a non-error result");
`endif

endmodule

// ===== design/tzif_footer_extractor.sv =====
// TZif footer extractor, top level. A word's first result passes through the command queue and
// the output register; held whitespace flushed ahead of it adds the registered buffer reads.
// Throughput: one word per cycle, set by the parser; it stalls only on a full command queue.
// A character after k > 0 held whitespace words steps through FLUSH_A and FLUSH_D per word, as
// each buffer read is registered, then ST_CHAR; one on the last word adds a done result.
// Reset (rst, synchronous) clears parser, queue and result_valid, not the whitespace buffer.
`timescale 1ns / 1ps

module tzif_footer_extractor #(
  parameter int PENDING_DEPTH = tfe_pkg::PENDING_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_file,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [1:0] kind,
  output logic [7:0] char_byte,
  output logic [2:0] error_code,
  output logic       last_of_run
);
  import tfe_pkg::*;

  localparam int CW = $clog2(PENDING_DEPTH + 1);

  logic          q_full;
  logic          q_empty;
  logic          cmd_push;
  logic          cmd_pop;
  cmd_t          push_cmd;
  cmd_t          head_cmd;
  logic [CW-1:0] push_count;
  logic [CW-1:0] head_count;

  tfe_front #(
    .PENDING_DEPTH(PENDING_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .data_byte  (data_byte),
    .end_of_file(end_of_file),
    .q_full     (q_full),
    .cmd_push   (cmd_push),
    .cmd        (push_cmd),
    .cmd_count  (push_count)
  );

  tfe_queue #(
    .PENDING_DEPTH(PENDING_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_cmd  (push_cmd),
    .push_count(push_count),
    .pop       (cmd_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head_cmd  (head_cmd),
    .head_count(head_count)
  );

  tfe_back #(
    .PENDING_DEPTH(PENDING_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_cmd    (head_cmd),
    .head_count  (head_count),
    .empty       (q_empty),
    .pop         (cmd_pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .kind        (kind),
    .char_byte   (char_byte),
    .error_code  (error_code),
    .last_of_run (last_of_run)
  );

endmodule
